/* hw/rtl/track_format_mark_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// track format mark parser assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TRACK_FORMAT_MARK_PARSER_UNIT_MACROS_SVH
`define TRACK_FORMAT_MARK_PARSER_UNIT_MACROS_SVH

// same-cycle implication check
`define TFMP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// next-cycle implication check
`define TFMP_ASSERT_NEXT(label, ante, cons, msg) \
	`TFMP_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* hw/rtl/tfmp_pkg.sv */
// ----------------------------------------------------------------------------
// tfmp_pkg
// types and constants of the track format mark parser
// ----------------------------------------------------------------------------
`default_nettype none

package tfmp_pkg;

	// sector buffer size and derived widths
	localparam int SECTOR_BYTES = 512;
	localparam int CNT_W        = $clog2(SECTOR_BYTES);
	localparam int LEN_W        = 11;
	localparam int INDEX_W      = 9;
	localparam int BUDGET_W     = 16;

	// configuration port
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam logic REG_TRACK_LENGTH = 1'b0;
	localparam logic [BUDGET_W-1:0] TRACK_LENGTH_RESET = 16'd6250;

	// track marks
	localparam logic [7:0] MARK_ID      = 8'hFE;
	localparam logic [7:0] MARK_DATA    = 8'hFB;
	localparam logic [7:0] MARK_DELETED = 8'hF8;

	// field length base
	localparam logic [LEN_W-1:0] FIELD_BASE = 11'd128;

	// item action codes
	typedef enum logic {
		ACT_START = 1'b0,
		ACT_BYTE  = 1'b1
	} action_t;

	// start answers
	typedef enum logic [1:0] {
		ST_ARMED     = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_WPROT     = 2'd2
	} start_status_t;

	// parser mode
	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_ID   = 2'd1,
		MODE_DATA = 2'd2
	} parse_mode_t;

	// input word
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       drive_ready;
		logic       write_protected;
	} item_t;

	// result word
	typedef struct packed {
		logic [1:0]         start_status;
		logic               byte_valid;
		logic [INDEX_W-1:0] byte_index;
		logic [7:0]         byte_value;
		logic               sector_done;
		logic [7:0]         cylinder;
		logic [7:0]         head;
		logic [7:0]         record;
		logic               track_done;
	} result_t;

	// parser status seen by the top level
	typedef struct packed {
		logic        armed;
		parse_mode_t mode;
	} parse_status_t;

endpackage

`default_nettype wire

/* hw/rtl/tfmp_regs.sv */
// ----------------------------------------------------------------------------
// tfmp_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module tfmp_regs
	import tfmp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic     [BUDGET_W-1:0] track_length
);

	logic [BUDGET_W-1:0] track_length_q;
	logic                wr_en;
	logic                sel_idx;

	// word index from the byte address
	assign sel_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// track length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_length_q <= TRACK_LENGTH_RESET;
		end else if (wr_en && sel_idx == REG_TRACK_LENGTH) begin
			track_length_q <= pwdata[BUDGET_W-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (sel_idx == REG_TRACK_LENGTH) begin
			prdata = {{(PDATA_W-BUDGET_W){1'b0}}, track_length_q};
		end
	end

	assign track_length = track_length_q;

endmodule

`default_nettype wire

/* hw/rtl/tfmp_parser.sv */
// ----------------------------------------------------------------------------
// tfmp_parser
// parse state and combinational next-state and result logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "track_format_mark_parser_unit_macros.svh"

module tfmp_parser
	import tfmp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire item_t               item_s1,
	input  wire logic [BUDGET_W-1:0] track_length,
	output result_t                  result,
	output parse_status_t            status
);

	logic                armed_q;
	parse_mode_t         mode_q;
	logic [CNT_W-1:0]    field_count_q;
	logic [7:0]          id_bytes_q [4];
	logic [BUDGET_W-1:0] bytes_left_q;

	logic                armed_d;
	parse_mode_t         mode_d;
	logic [CNT_W-1:0]    field_count_d;
	logic [BUDGET_W-1:0] bytes_left_d;
	logic                id_we;
	logic [1:0]          id_sel;
	logic [LEN_W-1:0]    len_full;
	logic [LEN_W-1:0]    len_cap;
	logic [LEN_W-1:0]    idx_next;
	logic                field_last;

	// data field length from size code, capped at the buffer size
	assign len_full   = FIELD_BASE << id_bytes_q[3][1:0];
	assign len_cap    = (len_full > LEN_W'(SECTOR_BYTES)) ? LEN_W'(SECTOR_BYTES) : len_full;
	assign idx_next   = LEN_W'(field_count_q) + LEN_W'(1);
	assign field_last = (idx_next >= len_cap);
	assign id_sel     = field_count_q[1:0];

	// next state and result
	always_comb begin
		armed_d       = armed_q;
		mode_d        = mode_q;
		field_count_d = field_count_q;
		bytes_left_d  = bytes_left_q;
		id_we         = 1'b0;
		result        = '0;
		if (item_s1.action == ACT_START) begin
			if (!item_s1.drive_ready) begin
				result.start_status = ST_NOT_READY;
				armed_d = 1'b0;
			end else if (item_s1.write_protected) begin
				result.start_status = ST_WPROT;
				armed_d = 1'b0;
			end else begin
				result.start_status = ST_ARMED;
				armed_d       = 1'b1;
				mode_d        = MODE_WAIT;
				field_count_d = '0;
				bytes_left_d  = track_length;
			end
		end else if (armed_q) begin
			if (bytes_left_q != '0) begin
				bytes_left_d = bytes_left_q - BUDGET_W'(1);
			end
			case (mode_q)
				MODE_ID: begin
					id_we = 1'b1;
					if (id_sel == 2'd3) begin
						mode_d        = MODE_WAIT;
						field_count_d = '0;
					end else begin
						field_count_d = CNT_W'(id_sel) + CNT_W'(1);
					end
				end
				MODE_DATA: begin
					result.byte_valid = 1'b1;
					result.byte_index = INDEX_W'(field_count_q);
					result.byte_value = item_s1.data_byte;
					if (field_last) begin
						result.sector_done = 1'b1;
						result.cylinder    = id_bytes_q[0];
						result.head        = id_bytes_q[1];
						result.record      = id_bytes_q[2];
						mode_d             = MODE_WAIT;
						field_count_d      = '0;
					end else begin
						field_count_d = CNT_W'(idx_next);
					end
				end
				default: begin
					if (item_s1.data_byte == MARK_ID) begin
						mode_d        = MODE_ID;
						field_count_d = '0;
					end else if (item_s1.data_byte == MARK_DATA ||
						item_s1.data_byte == MARK_DELETED) begin
						mode_d        = MODE_DATA;
						field_count_d = '0;
					end else begin
						mode_d = MODE_WAIT;
					end
				end
			endcase
			if (bytes_left_d == '0) begin
				result.track_done = 1'b1;
				armed_d = 1'b0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			mode_q        <= MODE_WAIT;
			field_count_q <= '0;
			bytes_left_q  <= '0;
		end else if (step) begin
			armed_q       <= armed_d;
			mode_q        <= mode_d;
			field_count_q <= field_count_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

	// captured id bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				id_bytes_q[i] <= '0;
			end
		end else if (step && id_we) begin
			id_bytes_q[id_sel] <= item_s1.data_byte;
		end
	end

	assign status.armed = armed_q;
	assign status.mode  = mode_q;

	// id collection never runs past four bytes
	`TFMP_ASSERT(a_id_count, (mode_q == MODE_ID) |-> (field_count_q < CNT_W'(4)), "id count overrun")
	// data index stays inside the field
	`TFMP_ASSERT(a_data_count, (mode_q == MODE_DATA) |-> (LEN_W'(field_count_q) < len_cap), "data index overrun")
	// disarm only happens on a processed word
	`TFMP_ASSERT(a_disarm_step, $fell(armed_q) |-> $past(step), "disarm without word")

endmodule

`default_nettype wire

/* hw/rtl/track_format_mark_parser_unit.sv */
// an accepted word passes through the input register, then its result through the result register
// throughput: one word per cycle, sustained under no output stall
// the input register and the result register each take a new word whenever
// the stage ahead moves, so stalls on the result side back up one stage
// reset: parser disarmed, mode waiting for mark, id bytes and budget zero,
// track_length 6250, both pipeline stages empty
// ----------------------------------------------------------------------------
// track_format_mark_parser_unit
// track-format byte stream parser with id/data mark capture and byte budget
// ----------------------------------------------------------------------------
`default_nettype none
`include "track_format_mark_parser_unit_macros.svh"

module track_format_mark_parser_unit
	import tfmp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire item_t              item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output result_t                 result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic                valid_s1;
	item_t               item_s1;
	logic                valid_s2;
	result_t             result_s2;
	result_t             result_d;
	parse_status_t       status;
	logic                advance;
	logic                step;
	logic [BUDGET_W-1:0] track_length;

	// configuration registers
	tfmp_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.track_length (track_length)
	);

	// pipeline flow control
	assign advance    = !valid_s2 || result_ready;
	assign step       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// parser core
	tfmp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item_s1      (item_s1),
		.track_length (track_length),
		.result       (result_d),
		.status       (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// input side only stalls with both stages full
	`TFMP_ASSERT(a_stall_full, !item_ready |-> (valid_s1 && valid_s2), "stall with free stage")
	// a completed sector always carries its last byte
	`TFMP_ASSERT(a_done_byte, (valid_s2 && result_s2.sector_done) |-> result_s2.byte_valid, "sector done without byte")
	// byte results never carry a start answer
	`TFMP_ASSERT(a_byte_status, (valid_s2 && result_s2.byte_valid) |-> (result_s2.start_status == ST_ARMED), "status on byte word")
	// a track end leaves the parser disarmed
	`TFMP_ASSERT_NEXT(a_track_end, step && result_d.track_done, !status.armed, "armed after track end")

endmodule

`default_nettype wire

/* bench/track_format_mark_parser_unit_tb.sv */
// ----------------------------------------------------------------------------
// track_format_mark_parser_unit_tb
// drives format commands and raw track words through the parser under random
// handshake gaps, predicts every result word and compares field by field
// ----------------------------------------------------------------------------
module track_format_mark_parser_unit_tb
	import tfmp_pkg::*;
();

	localparam int IDLE_MAX       = 19;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 600;
	localparam int DRAIN_CYCLES   = 8;

	typedef enum logic {
		ROW_WORD,
		ROW_LENGTH
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		item_t               word;
		logic [BUDGET_W-1:0] length;
		bit                  typed;
		result_t             want;
	} stim_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	result_t            result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// format command state as the parser should hold it
	logic [BUDGET_W-1:0] fmt_track_length = TRACK_LENGTH_RESET;
	logic [BUDGET_W-1:0] fmt_bytes_left   = '0;
	bit                  fmt_armed        = 1'b0;
	parse_mode_t         fmt_mode         = MODE_WAIT;
	int                  fmt_count        = 0;
	logic [7:0]          fmt_id [4]       = '{default: 8'h00};

	result_t    pending_results [$];
	logic [7:0] track_bytes [$];
	int         mismatches   = 0;
	int         words_sent   = 0;
	int         stuck_cycles = 0;
	int         rx_hold      = 0;
	int         rx_draw;
	bit         tx_quiet     = 1'b0;
	bit         rx_quiet     = 1'b0;

	track_format_mark_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	function automatic int draw_idle(bit quiet);
		return quiet ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	// next result word of the parser, advancing the tracked state
	function automatic result_t predict_word(item_t w);
		result_t r;
		int      flen;
		r = '0;
		if (w.action == ACT_START) begin
			if (!w.drive_ready) begin
				r.start_status = ST_NOT_READY;
				fmt_armed = 1'b0;
			end else if (w.write_protected) begin
				r.start_status = ST_WPROT;
				fmt_armed = 1'b0;
			end else begin
				r.start_status = ST_ARMED;
				fmt_armed = 1'b1;
				fmt_mode = MODE_WAIT;
				fmt_count = 0;
				fmt_bytes_left = fmt_track_length;
			end
		end else if (fmt_armed) begin
			if (fmt_bytes_left != 0)
				fmt_bytes_left = fmt_bytes_left - 1'b1;
			case (fmt_mode)
				MODE_ID: begin
					fmt_id[fmt_count & 3] = w.data_byte;
					if ((fmt_count & 3) == 3) begin
						fmt_mode = MODE_WAIT;
						fmt_count = 0;
					end else begin
						fmt_count = (fmt_count & 3) + 1;
					end
				end
				MODE_DATA: begin
					// field length from the size code, capped at the buffer
					flen = int'(FIELD_BASE) << fmt_id[3][1:0];
					if (flen > SECTOR_BYTES)
						flen = SECTOR_BYTES;
					r.byte_valid = 1'b1;
					r.byte_index = INDEX_W'(fmt_count);
					r.byte_value = w.data_byte;
					if (fmt_count + 1 >= flen) begin
						r.sector_done = 1'b1;
						r.cylinder = fmt_id[0];
						r.head = fmt_id[1];
						r.record = fmt_id[2];
						fmt_mode = MODE_WAIT;
						fmt_count = 0;
					end else begin
						fmt_count = fmt_count + 1;
					end
				end
				default: begin
					if (w.data_byte == MARK_ID) begin
						fmt_mode = MODE_ID;
						fmt_count = 0;
					end else if (w.data_byte == MARK_DATA || w.data_byte == MARK_DELETED) begin
						fmt_mode = MODE_DATA;
						fmt_count = 0;
					end else begin
						fmt_mode = MODE_WAIT;
					end
				end
			endcase
			if (fmt_bytes_left == 0) begin
				r.track_done = 1'b1;
				fmt_armed = 1'b0;
			end
		end
		return r;
	endfunction

	// typed results for the directed rows
	function automatic result_t status_word(start_status_t s);
		result_t r;
		r = '0;
		r.start_status = s;
		return r;
	endfunction

	function automatic result_t done_word();
		result_t r;
		r = '0;
		r.track_done = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t start_row(logic rdy, logic wp, bit typed, result_t want);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.word = '0;
		r.word.action = ACT_START;
		r.word.drive_ready = rdy;
		r.word.write_protected = wp;
		r.length = '0;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t byte_row(logic [7:0] b, bit typed, result_t want);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.word = '0;
		r.word.action = ACT_BYTE;
		r.word.data_byte = b;
		r.word.drive_ready = 1'b1;
		r.length = '0;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t length_row(logic [BUDGET_W-1:0] v);
		stim_row_t r;
		r.kind = ROW_LENGTH;
		r.word = '0;
		r.length = v;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// offer one word, keeping valid high across back-to-back words
	task automatic send_word(input item_t w, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		gap = draw_idle(tx_quiet);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		words_sent++;
		predicted = predict_word(w);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// block is idle once every expected word has come back
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_track_length(input logic [BUDGET_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(REG_TRACK_LENGTH));
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		fmt_track_length = v;
	endtask

	// one random track: filler, occasional broken pieces, then id and data fields
	task automatic build_track();
		int         sectors;
		int         n;
		logic [7:0] size_code;
		track_bytes.delete();
		sectors = $urandom_range(1, 2);
		repeat (sectors) begin
			repeat ($urandom_range(0, 3)) track_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 5) == 0) begin
				track_bytes.push_back($urandom_range(0, 1) ? MARK_ID : MARK_DATA);
				repeat ($urandom_range(0, 3)) track_bytes.push_back(8'($urandom));
			end
			track_bytes.push_back(MARK_ID);
			repeat (3) track_bytes.push_back(8'($urandom));
			size_code = 8'($urandom);
			if ($urandom_range(0, 5) != 0)
				size_code[1:0] = 2'b00;
			track_bytes.push_back(size_code);
			track_bytes.push_back($urandom_range(0, 1) ? MARK_DATA : MARK_DELETED);
			n = int'(FIELD_BASE) << size_code[1:0];
			if (n > SECTOR_BYTES)
				n = SECTOR_BYTES;
			repeat (n) track_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result word with nothing expected: %h", got);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			if (got.start_status !== want.start_status) begin
				$error("start_status expected %0d got %0d", want.start_status, got.start_status);
				mismatches++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid expected %0d got %0d", want.byte_valid, got.byte_valid);
				mismatches++;
			end
			if (got.byte_index !== want.byte_index) begin
				$error("byte_index expected %0d got %0d", want.byte_index, got.byte_index);
				mismatches++;
			end
			if (got.byte_value !== want.byte_value) begin
				$error("byte_value expected %h got %h", want.byte_value, got.byte_value);
				mismatches++;
			end
			if (got.sector_done !== want.sector_done) begin
				$error("sector_done expected %0d got %0d", want.sector_done, got.sector_done);
				mismatches++;
			end
			if (got.cylinder !== want.cylinder) begin
				$error("cylinder expected %h got %h", want.cylinder, got.cylinder);
				mismatches++;
			end
			if (got.head !== want.head) begin
				$error("head expected %h got %h", want.head, got.head);
				mismatches++;
			end
			if (got.record !== want.record) begin
				$error("record expected %h got %h", want.record, got.record);
				mismatches++;
			end
			if (got.track_done !== want.track_done) begin
				$error("track_done expected %0d got %0d", want.track_done, got.track_done);
				mismatches++;
			end
		end
	endtask

	// result side: check each word, then drop ready for a random idle draw, if nonzero
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_hold <= 0;
		end else if (result_ready) begin
			if (result_valid) begin
				check_result(result);
				rx_draw = draw_idle(rx_quiet);
				if (rx_draw != 0) begin
					result_ready <= 1'b0;
					rx_hold <= rx_draw - 1;
				end
			end
		end else if (rx_hold == 0) begin
			result_ready <= 1'b1;
		end else begin
			rx_hold <= rx_hold - 1;
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		stim_row_t           plan [$];
		item_t               w;
		logic [BUDGET_W-1:0] len;
		int                  restart_at;
		bit                  refuse;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reset budget first
		plan.push_back(byte_row(MARK_ID, 1'b1, '0));
		plan.push_back(start_row(1'b0, 1'b1, 1'b1, status_word(ST_NOT_READY)));
		plan.push_back(start_row(1'b0, 1'b0, 1'b1, status_word(ST_NOT_READY)));
		plan.push_back(start_row(1'b1, 1'b1, 1'b1, status_word(ST_WPROT)));
		plan.push_back(byte_row(8'hFF, 1'b1, '0));
		plan.push_back(start_row(1'b1, 1'b0, 1'b1, status_word(ST_ARMED)));
		plan.push_back(byte_row(8'h00, 1'b1, '0));
		plan.push_back(byte_row(MARK_ID, 1'b1, '0));
		plan.push_back(byte_row(8'hFF, 1'b1, '0));
		plan.push_back(byte_row(8'h00, 1'b1, '0));
		plan.push_back(byte_row(8'h5A, 1'b1, '0));
		// largest size code, field capped at the buffer size
		plan.push_back(byte_row(8'hFF, 1'b1, '0));
		plan.push_back(byte_row(MARK_DELETED, 1'b1, '0));
		plan.push_back(byte_row(8'hFF, 1'b0, '0));
		plan.push_back(byte_row(8'h00, 1'b0, '0));
		// restart while armed drops back to mark search
		plan.push_back(start_row(1'b1, 1'b0, 1'b1, status_word(ST_ARMED)));
		plan.push_back(byte_row(MARK_DATA, 1'b1, '0));
		plan.push_back(byte_row(8'hA5, 1'b0, '0));
		// single word budget
		plan.push_back(length_row(16'd1));
		plan.push_back(start_row(1'b1, 1'b0, 1'b1, status_word(ST_ARMED)));
		plan.push_back(byte_row(8'h12, 1'b1, done_word()));
		plan.push_back(byte_row(8'h34, 1'b1, '0));
		// zero budget acts like one
		plan.push_back(length_row(16'd0));
		plan.push_back(start_row(1'b1, 1'b0, 1'b1, status_word(ST_ARMED)));
		plan.push_back(byte_row(MARK_ID, 1'b1, done_word()));
		plan.push_back(length_row(16'hFFFF));
		plan.push_back(start_row(1'b1, 1'b0, 1'b1, status_word(ST_ARMED)));
		plan.push_back(byte_row(8'h03, 1'b0, '0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_LENGTH) begin
				wait_idle();
				write_track_length(plan[i].length);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		// random tracks, each with its own budget and idling pattern
		while (words_sent < RANDOM_WORDS) begin
			build_track();
			case ($urandom_range(0, 4))
				0: len = BUDGET_W'(track_bytes.size());
				1: len = BUDGET_W'($urandom_range(1, track_bytes.size()));
				2: len = 16'hFFFF;
				3: len = BUDGET_W'($urandom_range(1, 16'hFFFF));
				default: len = BUDGET_W'(track_bytes.size() + $urandom_range(1, 8));
			endcase
			wait_idle();
			write_track_length(len);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);

			// mostly a good start, sometimes a random drive status
			refuse = ($urandom_range(0, 5) == 0);
			w = '0;
			w.action = ACT_START;
			w.data_byte = 8'($urandom);
			w.drive_ready = refuse ? 1'($urandom) : 1'b1;
			w.write_protected = refuse ? 1'($urandom) : 1'b0;
			send_word(w, 1'b0, '0);

			restart_at = ($urandom_range(0, 7) == 0) ?
				$urandom_range(0, track_bytes.size() - 1) : -1;
			foreach (track_bytes[i]) begin
				// stop once the word count is reached
				if (words_sent >= RANDOM_WORDS)
					break;
				w = '0;
				w.action = ACT_BYTE;
				w.data_byte = track_bytes[i];
				w.drive_ready = 1'($urandom);
				w.write_protected = 1'($urandom);
				if (i == restart_at) begin
					w.action = ACT_START;
					w.drive_ready = 1'b1;
					w.write_protected = 1'b0;
				end
				send_word(w, 1'b0, '0);
			end
		end

		// drain and finish
		tx_quiet = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
